[hdl/clnw_pkg.sv]
// shared types, constants and the start-up command table for the lcd nibble writer
// no dependencies; imported by every module of the block
package clnw_pkg;

   localparam int STEP_WAIT_W     = 10;
   localparam int WAIT_W          = 11;
   localparam int START_BYTES     = 6;
   localparam int STATES_PER_BYTE = 6;
   localparam int IDX_W           = $clog2(START_BYTES);
   localparam int PHASE_W         = $clog2(STATES_PER_BYTE);
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [IDX_W-1:0]       LAST_IDX        = IDX_W'(START_BYTES - 1);
   localparam logic [PHASE_W-1:0]     LAST_PHASE      = PHASE_W'(STATES_PER_BYTE - 1);
   localparam logic [STEP_WAIT_W-1:0] STEP_WAIT_RESET = STEP_WAIT_W'(1);

   // input op codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_INIT  = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] data;
      logic       is_char;
   } req_type;

   typedef struct packed {
      logic              reg_select;
      logic              enable;
      logic [3:0]        nibble;
      logic [WAIT_W-1:0] wait_units;
      logic              last;
   } rsp_type;

   // one byte to put on the bus, as queued between front and back
   typedef struct packed {
      logic [7:0] data;
      logic       rs;
      logic       fin;   // last byte of its input item
      logic       dbl;   // final state holds twice as long
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [7:0] start_byte(input logic [IDX_W-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h33;
         3'd1:    b = 8'h32;
         3'd2:    b = 8'h06;
         3'd3:    b = 8'h0C;
         3'd4:    b = 8'h28;
         default: b = 8'h01;
      endcase
      return b;
   endfunction

endpackage

[hdl/clnw_front.sv]
// front end: accepts commands and splits them into byte jobs for the queue
// depends on clnw_pkg
module clnw_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  clnw_pkg::req_type         req_item,
   input  clnw_pkg::queue_status_type q_status,
   output clnw_pkg::push_type        push
);
   import clnw_pkg::*;

   typedef enum logic [1:0] {
      FR_IDLE = 2'b01,
      FR_INIT = 2'b10
   } fr_state_type;

   fr_state_type     state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;

   assign busy   = (state_ff == FR_INIT) || q_status.full;
   assign accept = start && !busy;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      push.push     = 1'b0;
      push.job.data = req_item.data;
      push.job.rs   = req_item.is_char;
      push.job.fin  = 1'b1;
      push.job.dbl  = 1'b0;
      unique case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               push.push = 1'b1;
               if (req_item.op == OP_INIT) begin
                  push.job.data = start_byte('0);
                  push.job.rs   = 1'b0;
                  push.job.fin  = 1'b0;
                  state_in      = FR_INIT;
                  idx_in        = IDX_W'(1);
               end
            end
         end
         FR_INIT: begin
            push.job.data = start_byte(idx_ff);
            push.job.rs   = 1'b0;
            push.job.fin  = (idx_ff == LAST_IDX);
            push.job.dbl  = (idx_ff == LAST_IDX);
            if (!q_status.full) begin
               push.push = 1'b1;
               idx_in    = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = FR_IDLE;
               end
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

[hdl/clnw_queue.sv]
// short job queue between front and back ends
// depends on clnw_pkg
module clnw_queue #(
   parameter int DEPTH = clnw_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  clnw_pkg::push_type        push,
   input  logic                      pop,
   output clnw_pkg::job_type         head,
   output clnw_pkg::queue_status_type status
);
   import clnw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head             = mem_ff[rd_ptr_ff];

   assign do_push = push.push && !status.full;
   assign do_pop  = pop && status.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/clnw_back.sv]
// back end: plays each queued byte out as six pin states, one a cycle
// depends on clnw_pkg
module clnw_back (
   input  logic                               clock,
   input  logic                               reset,
   input  clnw_pkg::job_type                  head,
   input  clnw_pkg::queue_status_type         q_status,
   input  logic [clnw_pkg::STEP_WAIT_W-1:0]   step_wait,
   output logic                               pop,
   output logic                               rsp_strobe,
   output clnw_pkg::rsp_type                  rsp_item
);
   import clnw_pkg::*;

   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic                   strobe_ff, strobe_in;
   rsp_type                rsp_ff, rsp_in;
   logic [STEP_WAIT_W-1:0] hold;
   logic                   hi_half;
   logic                   end_phase;

   // zero step wait behaves as one
   assign hold      = (step_wait == '0) ? STEP_WAIT_W'(1) : step_wait;
   assign hi_half   = (phase_ff < PHASE_W'(STATES_PER_BYTE / 2));
   assign end_phase = (phase_ff == LAST_PHASE);
   assign pop       = q_status.not_empty && end_phase;

   always_comb begin
      phase_in          = phase_ff;
      strobe_in         = q_status.not_empty;
      rsp_in.reg_select = head.rs;
      rsp_in.enable     = (phase_ff == PHASE_W'(1)) || (phase_ff == PHASE_W'(4));
      rsp_in.nibble     = hi_half ? head.data[7:4] : head.data[3:0];
      rsp_in.wait_units = (head.dbl && end_phase) ? {hold, 1'b0} : {1'b0, hold};
      rsp_in.last       = head.fin && end_phase;
      if (q_status.not_empty) begin
         phase_in = end_phase ? '0 : phase_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

[hdl/char_lcd_nibble_writer.sv]
// top level of the character lcd 4-bit bus writer
// depends on clnw_pkg, clnw_front, clnw_queue, clnw_back
// usage
//   command channel: pulse start with req_item while busy is low; the beat is
//   taken on that edge. op write sends one byte (data, is_char as register
//   select); op init sends the six start-up commands 33 32 06 0C 28 01
//   result channel: rsp_strobe is high for one cycle per pin state, with
//   rs, enable, d4..d7, hold time in step units and a last flag in rsp_item
//   the receiver has no back-pressure: every strobed beat is taken
//   config channel: csr_data written when csr_valid and csr_ready (always
//   ready); holds step_wait, reset value 1, zero acts as one
// timing
//   the first pin state strobes once its job has passed the job queue and
//   the output registers; a byte write gives 6 states, init gives 36;
//   the back end drains one state per cycle while the queue holds a job,
//   stepping its six-phase counter; new commands are taken meanwhile
//   busy rises while init is being split up or the job queue is full
// reset
//   synchronous, clears front state, queue pointers and the output strobe;
//   step_wait returns to 1
module char_lcd_nibble_writer #(
   parameter int QUEUE_DEPTH = clnw_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // command channel
   input  logic                             start,
   output logic                             busy,
   input  clnw_pkg::req_type                req_item,
   // pin-state results
   output logic                             rsp_strobe,
   output clnw_pkg::rsp_type                rsp_item,
   // step wait register
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [clnw_pkg::STEP_WAIT_W-1:0] csr_data
);
   import clnw_pkg::*;

   logic [STEP_WAIT_W-1:0] step_wait_ff, step_wait_in;
   push_type               push;
   job_type                head;
   queue_status_type       q_status;
   logic                   pop;

   // register port never stalls
   assign csr_ready    = 1'b1;
   assign step_wait_in = (csr_valid && csr_ready) ? csr_data : step_wait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_wait_ff <= STEP_WAIT_RESET;
      end else begin
         step_wait_ff <= step_wait_in;
      end
   end

   // front: takes command beats, init expands into six byte jobs
   clnw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_status (q_status),
      .push     (push)
   );

   // decouples the splitter from the pin sequencer
   clnw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   // back: six pin states per byte, registered onto the result ports
   clnw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .step_wait  (step_wait_ff),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

[tb/tb.sv]
// self-checking testbench for the character lcd nibble writer
// depends on clnw_pkg and char_lcd_nibble_writer; reads and writes no files
`timescale 1ns / 1ps

module tb;
   import clnw_pkg::*;

   localparam int  CLOCK_PERIOD   = 20;
   localparam int  RESET_CYCLES   = 8;
   localparam int  CYCLE_LIMIT    = 400000;
   localparam int  SETTLE_CYCLES  = 10;
   localparam int  REPORT_LIMIT   = 50;
   localparam int  PHASE_ITEMS    = 96;

   // start-up command bytes, in the order they go out on the bus
   localparam logic [7:0] STARTUP_CMDS [START_BYTES] =
      '{8'h33, 8'h32, 8'h06, 8'h0C, 8'h28, 8'h01};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   start      = 1'b0;
   logic                   busy;
   req_type                req_item   = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_item;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [STEP_WAIT_W-1:0] csr_data   = '0;

   // predictor state: our own copy of the step wait register
   logic [STEP_WAIT_W-1:0] step_wait_now;

   // pin states still owed by the block, oldest first
   rsp_type pin_states_due [$];

   int failures        = 0;
   int items_sent      = 0;
   int inits_sent      = 0;
   int pin_states_seen = 0;
   int settings_used   = 0;
   int cycles          = 0;

   char_lcd_nibble_writer u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // expand one accepted command into the pin states it must produce
   function automatic void predict_pin_states(req_type r);
      logic [WAIT_W-1:0] hold;
      logic [7:0]        cur_byte;
      rsp_type           s;
      int                n;
      int                phase;
      hold = (step_wait_now == '0) ? WAIT_W'(1) : WAIT_W'(step_wait_now);
      n = (r.op == OP_INIT) ? START_BYTES * STATES_PER_BYTE : STATES_PER_BYTE;
      for (int k = 0; k < n; k++) begin
         // init bytes are always commands; a write uses is_char as rs
         cur_byte = (r.op == OP_INIT) ? STARTUP_CMDS[k / STATES_PER_BYTE] : r.data;
         phase = k % STATES_PER_BYTE;
         s.reg_select = (r.op == OP_INIT) ? 1'b0 : r.is_char;
         // enable is high only in the middle state of each nibble
         s.enable     = (phase % 3 == 1);
         s.nibble     = (phase < 3) ? cur_byte[7:4] : cur_byte[3:0];
         s.last       = (k == n - 1);
         // the closing state of the start-up sequence holds twice as long
         s.wait_units = (r.op == OP_INIT && s.last) ? WAIT_W'(2 * hold) : hold;
         pin_states_due.push_back(s);
      end
   endfunction

   function automatic void compare_field(string name, logic [31:0] expd, logic [31:0] got);
      if (got !== expd) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $error("%s: expected %0d, actual %0d", name, expd, got);
      end
   endfunction

   // results are registered at the rising edge, so sample them mid-cycle;
   // this keeps the check clear of the sender pushing at the rising edge
   always @(negedge clock) begin : check_pin_states
      rsp_type expd;
      if (!reset && rsp_strobe) begin
         if (pin_states_due.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $error("pin state beat with nothing expected: %h", rsp_item);
         end else begin
            expd = pin_states_due.pop_front();
            compare_field("reg_select", expd.reg_select, rsp_item.reg_select);
            compare_field("enable",     expd.enable,     rsp_item.enable);
            compare_field("nibble",     expd.nibble,     rsp_item.nibble);
            compare_field("wait_units", expd.wait_units, rsp_item.wait_units);
            compare_field("last",       expd.last,       rsp_item.last);
            pin_states_seen++;
         end
      end
   end

   // watchdog: a hung handshake ends the run here
   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // offer one command and hold it until the block takes it; start stays
   // high afterwards so the next call can follow on without a gap
   task automatic send_command(req_type r);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predict_pin_states(r);
      items_sent++;
      if (r.op == OP_INIT) inits_sent++;
   endtask

   task automatic send_write(logic [7:0] data, logic is_char);
      req_type r;
      r.op      = OP_WRITE;
      r.data    = data;
      r.is_char = is_char;
      send_command(r);
   endtask

   task automatic send_init();
      req_type r;
      // data and rs carry junk: the block must ignore them for init
      r.op      = OP_INIT;
      r.data    = 8'($urandom);
      r.is_char = 1'($urandom);
      send_command(r);
   endtask

   task automatic idle_for(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // pause the sender until every owed pin state has come out
   task automatic wait_drained();
      start <= 1'b0;
      while (pin_states_due.size() != 0) @(posedge clock);
      // a first state appears only after its job passes the queue and output registers
      repeat (4) @(posedge clock);
   endtask

   // only called with the block idle and the result queue empty
   task automatic write_step_wait(logic [STEP_WAIT_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid     <= 1'b0;
      step_wait_now  = v;
      settings_used++;
   endtask

   task automatic test_reset_default();
      // register left at its reset value of 1
      send_write(8'h00, 1'b0);
      send_write(8'hFF, 1'b1);
      idle_for(3);
      send_write(8'hA5, 1'b1);
      send_init();
      wait_drained();
   endtask

   task automatic test_back_to_back();
      // no idle cycles: the queue fills and busy must hold the sender off
      send_write(8'h5A, 1'b0);
      send_write(8'h0F, 1'b1);
      send_write(8'hF0, 1'b0);
      send_init();
      send_write(8'hC3, 1'b1);
      wait_drained();
   endtask

   task automatic test_step_wait_extremes();
      logic [STEP_WAIT_W-1:0] corner [4];
      // zero acts as one, 1000, the 10-bit maximum 1023, and back to one
      corner = '{10'd0, 10'd1000, 10'd1023, 10'd1};
      foreach (corner[i]) begin
         write_step_wait(corner[i]);
         send_write(8'($urandom), 1'($urandom));
         send_init();
         wait_drained();
      end
   endtask

   // random commands in bursts; mostly byte writes, some start-up runs
   task automatic run_traffic(int n_items);
      int sent;
      int burst;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 16);
         for (int j = 0; j < burst && sent < n_items; j++) begin
            if ($urandom_range(0, 9) == 0)
               send_init();
            else
               send_write(8'($urandom), 1'($urandom));
            sent++;
         end
         case ($urandom_range(0, 19))
            0:       wait_drained();
            1:       idle_for($urandom_range(20, 60));
            2, 3, 4: idle_for(0);
            default: idle_for($urandom_range(1, 9));
         endcase
      end
   endtask

   task automatic test_random_traffic();
      logic [STEP_WAIT_W-1:0] setting [5];
      setting = '{10'($urandom_range(1, 1000)), 10'd1023,
                  10'($urandom_range(0, 1023)), 10'd1000,
                  10'($urandom_range(2, 999))};
      foreach (setting[i]) begin
         write_step_wait(setting[i]);
         run_traffic(PHASE_ITEMS);
         wait_drained();
      end
   endtask

   initial begin
      step_wait_now = STEP_WAIT_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_default();
      test_back_to_back();
      test_step_wait_extremes();
      test_random_traffic();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("tb: %0d commands (%0d start-up runs) over %0d step-wait settings,",
               items_sent, inits_sent, settings_used);
      $display("tb: %0d pin states checked in %0d cycles", pin_states_seen, cycles);
      if (failures == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

[char_lcd_nibble_writer.f]
hdl/clnw_pkg.sv
hdl/clnw_front.sv
hdl/clnw_queue.sv
hdl/clnw_back.sv
hdl/char_lcd_nibble_writer.sv
tb/tb.sv
